// File: hw/rtl/sha256_byte_stream_hasher_assert.svh
// Assertion macros for the SHA-256 byte stream hasher.
// Expects aclk and aresetn in the scope where a macro is used.
`ifndef SHA256_BYTE_STREAM_HASHER_ASSERT_SVH
`define SHA256_BYTE_STREAM_HASHER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SBSH_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("sha256 hasher: check failed");

// Next-cycle implication, checked outside reset.
`define SBSH_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("sha256 hasher: check failed");

`endif

// File: hw/rtl/sha256_pkg.sv
// Shared types, constants and round functions of the SHA-256 hasher.
// No dependencies; used by sha256_core and the top level.
package sha256_pkg;

    typedef logic [31:0] word_t;
    typedef logic [7:0][31:0] hash_vec_t;   // element i is hash word i
    typedef logic [0:15][31:0] sched_t;     // element 0 is the oldest word

    typedef struct packed {
        logic       init;
        logic       start;
        logic       shift_en;
        logic [7:0] shift_byte;
    } core_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } core_sts_t;

    localparam hash_vec_t HASH_INIT = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667};

    localparam logic [7:0] PAD_MARK     = 8'h80;
    localparam logic [5:0] LEN_OFFSET   = 6'd56;
    localparam logic [5:0] FILL_LAST    = 6'd63;
    localparam logic [5:0] FILL_PAD_END = LEN_OFFSET - 6'd1;
    localparam logic [5:0] ROUND_LAST   = 6'd63;
    localparam logic [2:0] WORD_LAST    = 3'd7;

    function automatic word_t bsig0(input word_t x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic word_t bsig1(input word_t x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic word_t ssig0(input word_t x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic word_t ssig1(input word_t x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

    function automatic word_t round_k(input logic [5:0] idx);
        word_t k;
        case (idx)
            6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

endpackage

// File: hw/rtl/sha256_core.sv
// SHA-256 compression core: byte-loaded message window, one round per cycle.
// Depends on sha256_pkg.
module sha256_core import sha256_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  core_cmd_t cmd,
    output core_sts_t sts,
    output hash_vec_t hash_words
);

    hash_vec_t   hash_reg, hash_next;
    hash_vec_t   wv_reg, wv_next;
    sched_t      win_reg, win_next;
    logic [5:0]  round_reg, round_next;
    logic        busy_reg, busy_next;
    logic        fold_reg, fold_next;
    logic        done_reg, done_next;
    logic [511:0] win_flat;
    word_t       w_new, t1, t2, ch, maj;

    always_comb begin
        ch    = (wv_reg[4] & wv_reg[5]) ^ (~wv_reg[4] & wv_reg[6]);
        maj   = (wv_reg[0] & wv_reg[1]) ^ (wv_reg[0] & wv_reg[2]) ^ (wv_reg[1] & wv_reg[2]);
        t1    = wv_reg[7] + bsig1(wv_reg[4]) + ch + round_k(round_reg) + win_reg[0];
        t2    = bsig0(wv_reg[0]) + maj;
        w_new = ssig1(win_reg[14]) + win_reg[9] + ssig0(win_reg[1]) + win_reg[0];
        win_flat = win_reg;
    end

    always_comb begin
        win_next   = win_reg;
        wv_next    = wv_reg;
        hash_next  = hash_reg;
        round_next = round_reg;
        busy_next  = busy_reg;
        fold_next  = busy_reg && (round_reg == ROUND_LAST);
        done_next  = fold_reg;

        // advance the window by one word per round, else take a message byte
        if (busy_reg) begin
            win_next = {win_reg[1:15], w_new};
        end else if (cmd.shift_en) begin
            win_next = {win_flat[503:0], cmd.shift_byte};
        end

        if (cmd.start) begin
            wv_next    = hash_reg;
            round_next = 6'd0;
            busy_next  = 1'b1;
        end else if (busy_reg) begin
            wv_next[7] = wv_reg[6];
            wv_next[6] = wv_reg[5];
            wv_next[5] = wv_reg[4];
            wv_next[4] = wv_reg[3] + t1;
            wv_next[3] = wv_reg[2];
            wv_next[2] = wv_reg[1];
            wv_next[1] = wv_reg[0];
            wv_next[0] = t1 + t2;
            round_next = round_reg + 6'd1;
            if (round_reg == ROUND_LAST) begin
                busy_next = 1'b0;
            end
        end

        if (cmd.init) begin
            hash_next = HASH_INIT;
        end else if (fold_reg) begin
            for (int i = 0; i < 8; i++) begin
                hash_next[i] = hash_reg[i] + wv_reg[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        win_reg <= win_next;
        wv_reg  <= wv_next;
        if (!aresetn) begin
            hash_reg  <= HASH_INIT;
            round_reg <= 6'd0;
            busy_reg  <= 1'b0;
            fold_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end else begin
            hash_reg  <= hash_next;
            round_reg <= round_next;
            busy_reg  <= busy_next;
            fold_reg  <= fold_next;
            done_reg  <= done_next;
        end
    end

    assign sts.busy   = busy_reg | fold_reg;
    assign sts.done   = done_reg;
    assign hash_words = hash_reg;

endmodule

// File: hw/rtl/sha256_byte_stream_hasher.sv
// SHA-256 over a byte stream: one message byte per transaction, digest on finish.
// Each message byte is shifted in; the 64th byte of a block starts a compression
// (64 rounds of the shared round unit, a fold step, a handoff step), intake closed.
// Finish: padding is shifted in, each padded block (one or two) is compressed, then
// eight digest transactions follow, one per cycle when m_tready stays high.
// Reset (aresetn low, synchronous) loads the initial hash and clears length and fill.
`include "sha256_byte_stream_hasher_assert.svh"

module sha256_byte_stream_hasher import sha256_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] data_byte
    input  logic [0:0]  s_tuser,    // [0] kind: 0 = message byte, 1 = finish
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // [31:0] digest_word
    output logic [2:0]  m_tuser,    // [2:0] word_index
    output logic        m_tlast     // last_word
);

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;  // take message bytes
    localparam logic [2:0] S_COMP = 3'd1;  // wait for the compression core
    localparam logic [2:0] S_PADZ = 3'd2;  // shift zero padding bytes
    localparam logic [2:0] S_PADL = 3'd3;  // shift the eight length bytes
    localparam logic [2:0] S_EMIT = 3'd4;  // hand out the digest words

    localparam logic KIND_FINISH = 1'b1;

    logic [2:0]  state_reg, state_next;
    logic [2:0]  after_reg, after_next;     // state to resume after compression
    logic [5:0]  fill_reg, fill_next;       // bytes in the current block
    logic [63:0] len_reg, len_next;         // byte count, then bit count shifted out
    logic [2:0]  cnt_reg, cnt_next;         // length byte position
    logic        out_valid_reg, out_valid_next;
    word_t       out_word_reg, out_word_next;
    logic [2:0]  out_idx_reg, out_idx_next;

    core_cmd_t   core_cmd;
    core_sts_t   core_sts;
    hash_vec_t   hash_words;

    sha256_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (core_cmd),
        .sts        (core_sts),
        .hash_words (hash_words)
    );

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        state_next     = state_reg;
        after_next     = after_reg;
        fill_next      = fill_reg;
        len_next       = len_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        out_word_next  = out_word_reg;
        out_idx_next   = out_idx_reg;
        core_cmd       = '0;

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    core_cmd.shift_en = 1'b1;
                    fill_next         = fill_reg + 6'd1;
                    if (s_tuser[0] == KIND_FINISH) begin
                        // append the marker byte and latch the bit length
                        core_cmd.shift_byte = PAD_MARK;
                        len_next            = {len_reg[60:0], 3'b000};
                        cnt_next            = 3'd0;
                        if (fill_reg == FILL_LAST) begin
                            core_cmd.start = 1'b1;
                            state_next     = S_COMP;
                            after_next     = S_PADZ;
                        end else if (fill_reg == FILL_PAD_END) begin
                            state_next = S_PADL;
                        end else begin
                            state_next = S_PADZ;
                        end
                    end else begin
                        core_cmd.shift_byte = s_tdata;
                        len_next            = len_reg + 64'd1;
                        if (fill_reg == FILL_LAST) begin
                            core_cmd.start = 1'b1;
                            state_next     = S_COMP;
                            after_next     = S_IDLE;
                        end
                    end
                end
            end
            S_PADZ: begin
                core_cmd.shift_en   = 1'b1;
                core_cmd.shift_byte = 8'h00;
                fill_next           = fill_reg + 6'd1;
                if (fill_reg == FILL_LAST) begin
                    // block overflowed into an extra one: compress, then keep padding
                    core_cmd.start = 1'b1;
                    state_next     = S_COMP;
                    after_next     = S_PADZ;
                end else if (fill_reg == FILL_PAD_END) begin
                    state_next = S_PADL;
                end
            end
            S_PADL: begin
                core_cmd.shift_en   = 1'b1;
                core_cmd.shift_byte = len_reg[63:56];
                len_next            = {len_reg[55:0], 8'h00};
                fill_next           = fill_reg + 6'd1;
                cnt_next            = cnt_reg + 3'd1;
                if (cnt_reg == WORD_LAST) begin
                    core_cmd.start = 1'b1;
                    state_next     = S_COMP;
                    after_next     = S_EMIT;
                end
            end
            S_COMP: begin
                if (core_sts.done) begin
                    state_next = after_reg;
                    if (after_reg == S_EMIT) begin
                        out_valid_next = 1'b1;
                        out_word_next  = hash_words[0];
                        out_idx_next   = 3'd0;
                    end
                end
            end
            S_EMIT: begin
                if (m_tready) begin
                    if (out_idx_reg == WORD_LAST) begin
                        // drop the digest and start a fresh message
                        out_valid_next = 1'b0;
                        state_next     = S_IDLE;
                        core_cmd.init  = 1'b1;
                        len_next       = 64'd0;
                        fill_next      = 6'd0;
                    end else begin
                        out_idx_next  = out_idx_reg + 3'd1;
                        out_word_next = hash_words[out_idx_reg + 3'd1];
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        out_word_reg <= out_word_next;
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            after_reg     <= S_IDLE;
            fill_reg      <= 6'd0;
            len_reg       <= 64'd0;
            cnt_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
            out_idx_reg   <= 3'd0;
        end else begin
            state_reg     <= state_next;
            after_reg     <= after_next;
            fill_reg      <= fill_next;
            len_reg       <= len_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            out_idx_reg   <= out_idx_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_word_reg;
    assign m_tuser  = out_idx_reg;
    assign m_tlast  = (out_idx_reg == WORD_LAST);

    // input side stays closed while a digest is pending or the core is running
    `SBSH_ASSERT_IMP(a_no_intake_while_emit, m_tvalid, !s_tready)
    `SBSH_ASSERT_IMP(a_no_intake_while_busy, core_sts.busy, !s_tready)
    // length bytes always land in the final eight byte slots of a block
    `SBSH_ASSERT_IMP(a_len_slot, state_reg == S_PADL, fill_reg[5:3] == 3'b111)
    // the final digest transaction closes the output
    `SBSH_ASSERT_NXT(a_last_closes, m_tvalid && m_tready && m_tlast, !m_tvalid && s_tready)

endmodule
